### hdl/lnu_pkg.sv
// Package for the leaky integrate-and-fire neuron update unit.
// Holds the request and result payload types, register indexes and fixed-point constants.
// No dependencies.
`default_nettype none

package lnu_pkg;

	// Opcode values of the time field.
	localparam logic OP_ABSOLUTE = 1'b0;
	localparam logic OP_DELTA    = 1'b1;

	// Configuration register indexes and port widths.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RESTING   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DECAY     = 2'd2;

	// Register reset values.
	localparam logic signed [31:0] THRESHOLD_RESET = 32'sd256000;
	localparam logic signed [31:0] RESTING_RESET   = 32'sd0;
	localparam logic [15:0]        DECAY_RESET     = 16'd24109;

	// Q0.16 constants: one and the rounding half.
	localparam logic [16:0] Q16_ONE  = 17'h10000;
	localparam logic [15:0] Q16_HALF = 16'h8000;

	// Saturation limits of the Q23.8 potential.
	localparam logic signed [31:0] POT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] POT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic               opcode;
		logic signed [23:0] input_current;
		logic [31:0]        time_value;
	} in_item_t;

	typedef struct packed {
		logic               spike;
		logic signed [31:0] potential_now;
		logic [31:0]        last_spike_time;
	} out_item_t;

endpackage

`default_nettype wire

### hdl/lnu_in_if.sv
// Request channel of the neuron update unit: valid, ready and one input item.
// Depends on lnu_pkg.
`default_nettype none

interface lnu_in_if import lnu_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hdl/lnu_out_if.sv
// Result channel of the neuron update unit: valid, ready and one result item.
// Depends on lnu_pkg.
`default_nettype none

interface lnu_out_if import lnu_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hdl/lif_neuron_update_unit.sv
// Leaky integrate-and-fire neuron update unit with one shared multiplier.
// Depends on lnu_pkg, lnu_in_if and lnu_out_if.
// A current that is not positive goes from request capture straight to the finish step;
// otherwise the square-and-multiply walk over the elapsed count comes first, then decay,
// rounding and finish. A new request is taken only after the last one has finished; the
// walk runs on the single 33 x 18 multiplier, and a stalled result holds the finish step.
// Reset: arst_n clears state, potential, times and output valid, and loads register defaults.
`default_nettype none

module lif_neuron_update_unit import lnu_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	lnu_in_if.sink                      item,
	lnu_out_if.source                   result,
	input  wire logic                   cfg_wen,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL    = 3'd1;
	localparam logic [2:0] ST_SQR    = 3'd2;
	localparam logic [2:0] ST_DECAY  = 3'd3;
	localparam logic [2:0] ST_ROUND  = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0]         state_q;
	logic signed [31:0] threshold_q;
	logic signed [31:0] resting_q;
	logic [15:0]        decay_q;
	logic signed [31:0] pot_q;
	logic [31:0]        last_update_q;
	logic [31:0]        spike_time_q;
	logic [31:0]        new_time_q;
	logic [31:0]        ticks_q;
	logic signed [23:0] current_q;
	logic               positive_q;
	logic [16:0]        result_q;
	logic [16:0]        base_q;
	logic signed [48:0] prod_q;
	logic signed [32:0] sum_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               accept;
	logic [31:0]        ticks_in;
	logic [31:0]        new_time_in;
	logic signed [32:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [50:0] mul_p;
	logic [33:0]        q16_sum;
	logic [16:0]        q16_res;
	logic signed [48:0] rnd_sum;
	logic signed [31:0] pot_sat;
	logic               out_free;

	assign item.ready   = (state_q == ST_IDLE);
	assign accept       = item.valid && item.ready;
	assign out_free     = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;
	assign result.payload = out_q;

	// Elapsed ticks and the new last-update time, from the opcode.
	always_comb begin
		if (item.payload.opcode == OP_DELTA) begin
			ticks_in    = item.payload.time_value;
			new_time_in = last_update_q + item.payload.time_value;
		end else begin
			ticks_in    = item.payload.time_value - last_update_q;
			new_time_in = item.payload.time_value;
		end
	end

	// Shared multiplier operand selection.
	always_comb begin
		unique case (state_q)
			ST_MUL: begin
				mul_a = {16'd0, result_q};
				mul_b = {1'b0, base_q};
			end
			ST_SQR: begin
				mul_a = {16'd0, base_q};
				mul_b = {1'b0, base_q};
			end
			ST_DECAY: begin
				mul_a = {pot_q[31], pot_q};
				mul_b = {1'b0, result_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	// Q0.16 product rounded half up; both factors stay at or below one.
	assign q16_sum = mul_p[33:0] + {18'd0, Q16_HALF};
	assign q16_res = q16_sum[32:16];
	// Decayed potential rounded half up toward plus infinity.
	assign rnd_sum = prod_q + {33'd0, Q16_HALF};

	// Saturate the potential plus current to the Q23.8 range.
	always_comb begin
		if (sum_q[32] != sum_q[31]) begin
			pot_sat = sum_q[32] ? POT_MIN : POT_MAX;
		end else begin
			pot_sat = sum_q[31:0];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			resting_q   <= RESTING_RESET;
			decay_q     <= DECAY_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_wdata;
				REG_RESTING:   resting_q   <= cfg_wdata;
				REG_DECAY:     decay_q     <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Result valid: set as a request finishes, cleared when the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer: request capture, exponent walk, decay, rounding and final update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pot_q         <= '0;
			last_update_q <= '0;
			spike_time_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!item.payload.input_current[23]
								&& (item.payload.input_current != '0)) begin
							if (ticks_in == '0) begin
								state_q <= ST_DECAY;
							end else if (ticks_in[0]) begin
								state_q <= ST_MUL;
							end else begin
								state_q <= ST_SQR;
							end
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_MUL: begin
					state_q <= (ticks_q[31:1] == '0) ? ST_DECAY : ST_SQR;
				end
				ST_SQR: begin
					state_q <= ticks_q[1] ? ST_MUL : ST_SQR;
				end
				ST_DECAY: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// Hold until the result register is free.
					if (out_free) begin
						state_q       <= ST_IDLE;
						last_update_q <= new_time_q;
						if (positive_q) begin
							if (pot_sat > threshold_q) begin
								pot_q        <= resting_q;
								spike_time_q <= new_time_q;
							end else begin
								pot_q <= pot_sat;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the shared unit and the result payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ticks_q    <= ticks_in;
					new_time_q <= new_time_in;
					current_q  <= item.payload.input_current;
					positive_q <= !item.payload.input_current[23]
						&& (item.payload.input_current != '0);
					result_q   <= Q16_ONE;
					base_q     <= {1'b0, decay_q};
				end
			end
			ST_MUL: begin
				result_q <= q16_res;
			end
			ST_SQR: begin
				base_q  <= q16_res;
				ticks_q <= {1'b0, ticks_q[31:1]};
			end
			ST_DECAY: begin
				prod_q <= mul_p[48:0];
			end
			ST_ROUND: begin
				sum_q <= {rnd_sum[47], rnd_sum[47:16]} + {{9{current_q[23]}}, current_q};
			end
			ST_FINISH: begin
				if (out_free) begin
					if (positive_q && (pot_sat > threshold_q)) begin
						out_q.spike           <= 1'b1;
						out_q.potential_now   <= resting_q;
						out_q.last_spike_time <= new_time_q;
					end else begin
						out_q.spike           <= 1'b0;
						out_q.potential_now   <= positive_q ? pot_sat : pot_q;
						out_q.last_spike_time <= spike_time_q;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

### hdl/lnu_checker.sv
// Port-level checks of the neuron update unit, attached to each instance of it by a bind.
// Depends on lnu_pkg and lif_neuron_update_unit.
`default_nettype none

module lnu_checker import lnu_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_payload
);

	// A result that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_payload))
		else $error("result payload changed while stalled");

	// The unit is busy in the cycle after it takes a request.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// A new result appears only as the unit finishes a request and frees up.
	a_result_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready && !$past(in_ready))
		else $error("result not tied to a finished request");

endmodule

bind lif_neuron_update_unit lnu_checker u_lnu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_payload (result.payload)
);

`default_nettype wire

### tb/lnu_update_checker.sv
// Checker for the neuron update unit: predicts each result and compares it with the block.
// Depends on lnu_pkg, lnu_in_if and lnu_out_if.
// Also follows the configuration port so that its register copy matches the block.

module lnu_update_checker import lnu_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	lnu_in_if                           req_ch,
	lnu_out_if                          res_ch,
	input  wire logic                   cfg_wen,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	output int unsigned                 outstanding,
	output int unsigned                 mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	// Register copy.
	logic signed [31:0] thr_q;
	logic signed [31:0] rest_q;
	logic [15:0]        decay_q;

	// Neuron state copy.
	logic signed [31:0] potential_q;
	logic [31:0]        last_update;
	logic [31:0]        last_fire;

	out_item_t   pending_results[$];
	int unsigned fail_total;

	// Decay factor: decay_q raised to the elapsed ticks, square-and-multiply, LSB first.
	function automatic logic [16:0] decay_gain(logic [31:0] ticks);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = 64'(Q16_ONE);
		sq  = 64'(decay_q);
		for (int b = 0; b < 32; b++) begin
			if (ticks[b]) begin
				acc = (acc * sq + 64'(Q16_HALF)) >> 16;
			end
			sq = (sq * sq + 64'(Q16_HALF)) >> 16;
		end
		return acc[16:0];
	endfunction

	// Potential times the Q0.16 factor, rounded half up toward plus infinity.
	function automatic longint decayed_potential(logic signed [31:0] pot, logic [16:0] gain);
		longint prod;
		prod = longint'(pot) * longint'({47'd0, gain});
		return (prod + 64'sd32768) >>> 16;
	endfunction

	// Apply one request to the state copy and return the result it should produce.
	function automatic out_item_t advance_neuron(in_item_t req);
		logic [31:0] ticks;
		logic [31:0] stamp;
		longint      sum;
		logic        fired;
		out_item_t   res;
		if (req.opcode == OP_DELTA) begin
			ticks = req.time_value;
			stamp = last_update + req.time_value;
		end else begin
			ticks = req.time_value - last_update;
			stamp = req.time_value;
		end
		fired = 1'b0;
		last_update = stamp;
		if ($signed(req.input_current) > 0) begin
			sum = decayed_potential(potential_q, decay_gain(ticks))
				+ longint'($signed(req.input_current));
			if (sum > longint'(POT_MAX)) begin
				sum = longint'(POT_MAX);
			end
			if (sum < longint'(POT_MIN)) begin
				sum = longint'(POT_MIN);
			end
			if (sum > longint'(thr_q)) begin
				potential_q = rest_q;
				last_fire   = stamp;
				fired       = 1'b1;
			end else begin
				potential_q = sum[31:0];
			end
		end
		res.spike           = fired;
		res.potential_now   = potential_q;
		res.last_spike_time = last_fire;
		return res;
	endfunction

	// Follow configuration writes, compare results, then predict for accepted requests.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			thr_q       = THRESHOLD_RESET;
			rest_q      = RESTING_RESET;
			decay_q     = DECAY_RESET;
			potential_q = '0;
			last_update = '0;
			last_fire   = '0;
			fail_total  = 0;
			pending_results.delete();
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_THRESHOLD: thr_q = cfg_wdata;
					REG_RESTING: rest_q = cfg_wdata;
					REG_DECAY: decay_q = cfg_wdata[15:0];
					default: ;
				endcase
			end

			// A result is checked before the same edge's request is predicted.
			if (res_ch.valid && res_ch.ready) begin
				got = res_ch.payload;
				if (pending_results.size() == 0) begin
					fail_total++;
					$error("result with no request outstanding: spike %0b potential %0d",
						got.spike, got.potential_now);
				end else begin
					want = pending_results.pop_front();
					if (got.spike !== want.spike) begin
						fail_total++;
						$error("spike: expected %0b, got %0b", want.spike, got.spike);
					end
					if (got.potential_now !== want.potential_now) begin
						fail_total++;
						$error("potential_now: expected %0d, got %0d",
							want.potential_now, got.potential_now);
					end
					if (got.last_spike_time !== want.last_spike_time) begin
						fail_total++;
						$error("last_spike_time: expected %0d, got %0d",
							want.last_spike_time, got.last_spike_time);
					end
				end
			end

			if (req_ch.valid && req_ch.ready) begin
				pending_results.push_back(advance_neuron(req_ch.payload));
			end

			outstanding <= pending_results.size();
			mismatches  <= fail_total;
		end
	end

endmodule

### tb/lif_neuron_update_unit_tb.sv
// Top of the neuron update unit testbench: clock, reset, stimulus, flow control and verdict.
// Depends on lnu_pkg, lnu_in_if, lnu_out_if, lif_neuron_update_unit and lnu_update_checker.

module lif_neuron_update_unit_tb import lnu_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT    = 1000000;
	localparam int unsigned PHASE_REQUESTS = 170;
	localparam int unsigned PHASE_COUNT    = 8;
	localparam int unsigned DRAIN_CYCLES   = 80;

	logic clk = 1'b0;
	logic arst_n;

	lnu_in_if  item_ch ();
	lnu_out_if res_ch ();

	logic                   cfg_wen;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	int unsigned outstanding;
	int unsigned mismatches;
	int unsigned cycles = 0;
	logic        quiet = 1'b0;
	logic [31:0] abs_stamp = '0;

	lif_neuron_update_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (res_ch),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	lnu_update_checker spike_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_ch     (item_ch),
		.res_ch     (res_ch),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.outstanding(outstanding),
		.mismatches (mismatches)
	);

	always #6 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Result side flow control: bursts of ready with random stalls.
	initial begin
		int unsigned stall;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= 1'b1;
			stall = quiet ? 0 : pick_gap();
			if (stall != 0) begin
				repeat ($urandom_range(0, 6)) @(posedge clk);
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Offer one request and hold it until accepted; valid stays high unless a gap follows.
	task automatic send(logic op, logic signed [23:0] cur, logic [31:0] tv);
		in_item_t    req;
		int unsigned gap;
		req.opcode        = op;
		req.input_current = cur;
		req.time_value    = tv;
		item_ch.payload <= req;
		item_ch.valid   <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		gap = quiet ? 0 : pick_gap();
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop requesting and wait until every predicted result has come back.
	task automatic settle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	// Write all three registers in consecutive cycles; the block must be idle.
	task automatic write_regs(logic [31:0] thr, logic [31:0] rest, logic [15:0] decay);
		cfg_wen   <= 1'b1;
		cfg_index <= REG_THRESHOLD;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_index <= REG_RESTING;
		cfg_wdata <= rest;
		@(posedge clk);
		cfg_index <= REG_DECAY;
		cfg_wdata <= {16'd0, decay};
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// One random request: moderate positive currents most often, and mostly short time steps.
	task automatic random_request();
		logic               op;
		logic signed [23:0] cur;
		logic [31:0]        tv;
		int unsigned        r;
		op = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (r < 45) begin
			cur = 24'($urandom_range(1, 40000));
		end else if (r < 60) begin
			cur = 24'($urandom_range(1, 24'h7FFFFF));
		end else if (r < 72) begin
			cur = 24'($urandom);
		end else if (r < 77) begin
			cur = '0;
		end else if (r < 84) begin
			cur = ($urandom_range(0, 1) != 0) ? 24'sh7FFFFF : 24'sh800000;
		end else begin
			cur = -24'($urandom_range(1, 100000));
		end
		r = $urandom_range(0, 99);
		if (op == OP_DELTA) begin
			if (r < 70) begin
				tv = $urandom_range(0, 4);
			end else if (r < 88) begin
				tv = $urandom_range(0, 1000);
			end else begin
				tv = $urandom;
			end
		end else begin
			if (r < 85) begin
				abs_stamp = abs_stamp + $urandom_range(0, 4);
			end else begin
				abs_stamp = $urandom;
			end
			tv = abs_stamp;
		end
		send(op, cur, tv);
	endtask

	initial begin
		item_ch.valid   = 1'b0;
		item_ch.payload = '0;
		cfg_wen         = 1'b0;
		cfg_index       = REG_THRESHOLD;
		cfg_wdata       = '0;
		arst_n          = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset registers, largest current fires at time zero.
		send(OP_ABSOLUTE, 24'sh7FFFFF, 32'd0);
		send(OP_ABSOLUTE, 24'sd1, 32'd5);
		// Zero or negative current only moves the time, in both modes.
		send(OP_ABSOLUTE, 24'sd0, 32'd10);
		send(OP_DELTA, 24'sd0, 32'd3);
		send(OP_DELTA, 24'sh800000, 32'hFFFF_FFFF);
		// Absolute time behind the last update wraps to a huge elapsed count.
		send(OP_ABSOLUTE, 24'sd300000, 32'd7);
		send(OP_DELTA, 24'sd1000, 32'hFFFF_FFFF);
		settle();

		// Threshold of 1.0: a potential equal to it does not fire, one LSB above does.
		write_regs(32'd256, 32'd0, 16'hFFFF);
		send(OP_DELTA, 24'sh7FFFFF, 32'd0);
		send(OP_DELTA, 24'sd256, 32'd0);
		send(OP_DELTA, 24'sd1, 32'd0);
		settle();

		// Lowest threshold: any positive current fires and loads a high resting level.
		write_regs(32'h8000_0000, 32'h7FFF_FF00, 16'd0);
		send(OP_ABSOLUTE, 24'sd1, 32'd50);
		send(OP_DELTA, 24'sd100, 32'd1);
		settle();

		// Highest threshold never fires; the potential saturates at the top.
		write_regs(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
		send(OP_DELTA, 24'sd1, 32'd1);
		send(OP_DELTA, 24'sh7FFFFF, 32'd0);
		send(OP_DELTA, 24'sh7FFFFF, 32'd0);
		send(OP_DELTA, 24'sh7FFFFF, 32'd1);
		send(OP_DELTA, 24'sh800000, 32'd2);
		settle();

		// Lowest resting level, then decay of a negative potential.
		write_regs(32'h8000_0000, 32'h8000_0000, 16'h8000);
		send(OP_DELTA, 24'sd1, 32'd0);
		settle();
		write_regs(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000);
		send(OP_DELTA, 24'sd1, 32'd0);
		send(OP_DELTA, 24'sd5, 32'd1);
		send(OP_ABSOLUTE, 24'sd3, 32'hAAAA_5555);
		settle();

		// Random phases, each under its own register setting.
		for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: write_regs(32'(THRESHOLD_RESET), 32'(RESTING_RESET), DECAY_RESET);
				1: write_regs(32'(256 * $urandom_range(10, 2000)), 32'($urandom_range(0, 5000)),
					16'($urandom));
				2: write_regs(32'h8000_0000, $urandom, 16'd0);
				3: write_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
				4: write_regs($urandom, $urandom, 16'($urandom));
				5: write_regs(32'd0, 32'h8000_0000, 16'hFFFF);
				6: write_regs(32'(256 * $urandom_range(1, 40000)), -32'($urandom_range(0, 99999)),
					16'($urandom_range(60000, 65535)));
				default: write_regs(32'($urandom_range(0, 2000000)), 32'($urandom_range(0, 1000)),
					16'($urandom));
			endcase
			quiet = (phase == 3) || (phase == 6);
			for (int unsigned n = 0; n < PHASE_REQUESTS; n++) begin
				random_request();
				// Now and then hold off until the block has answered everything.
				if ($urandom_range(0, 99) == 0) begin
					settle();
				end
			end
			settle();
		end
		quiet = 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### sim.f
hdl/lnu_pkg.sv
hdl/lnu_in_if.sv
hdl/lnu_out_if.sv
hdl/lif_neuron_update_unit.sv
hdl/lnu_checker.sv
tb/lnu_update_checker.sv
tb/lif_neuron_update_unit_tb.sv
